>>> rtl/smsu_pkg.sv
// Package for the substring match stream unit: request/response payload
// types, window sizing constants and register indexes. No dependencies.
package smsu_pkg;

   localparam int MAX_PATTERN  = 32;
   localparam int LENGTH_LIMIT = (MAX_PATTERN < 32) ? MAX_PATTERN : 32;
   localparam int COUNT_W      = $clog2(MAX_PATTERN + 1);
   localparam int LEN_W        = 6;
   localparam int PAT_REGS     = 4;
   localparam int PAT_BYTES    = PAT_REGS * 8;
   localparam int PAT_IDX_W    = $clog2(PAT_BYTES);
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 64;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATTERN_LENGTH = 3'd0,
      CSR_PATTERN_BYTES0 = 3'd1,
      CSR_PATTERN_BYTES1 = 3'd2,
      CSR_PATTERN_BYTES2 = 3'd3,
      CSR_PATTERN_BYTES3 = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       text_start;
      logic       text_end;
   } req_type;

   typedef struct packed {
      logic match_here;
      logic found_so_far;
      logic is_final;
   } rsp_type;

endpackage

>>> rtl/substring_match_stream_unit.sv
// Substring match stream unit: byte window, aligned pattern and compare.
// Depends on smsu_pkg.
//
// Usage:
//   req channel (req_valid/req_stall/req) carries one text byte with start
//   and end markers; a request is taken when req_valid is high and
//   req_stall is low. rsp channel (rsp_valid/rsp_stall/rsp) returns one
//   result per request in order: match_here, found_so_far, is_final.
//   csr channel (csr_valid/csr_ready/csr_index/csr_data) writes the pattern
//   length and the four pattern byte words; csr_ready is always high.
//   Write the csr registers only while no request is in flight.
// Timing:
//   One request per cycle sustained while rsp_stall is low. A request is taken
//   into the window register, which feeds a parallel compare against the
//   registered, length-aligned pattern; the compare loads the result register.
// Reset:
//   Synchronous, active high. Empties the pipeline, clears the byte count
//   and found flag, and sets pattern length 1 with pattern bytes zero.
// Backpressure:
//   While rsp_stall holds a result, one more request is taken into the
//   window stage; after that req_stall rises until the result is taken.
module substring_match_stream_unit
   import smsu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic [LEN_W-1:0]      pat_len_ff;
   logic [CSR_DATA_W-1:0] pat_word_ff [PAT_REGS];

   logic [LEN_W-1:0]      len_in,     len_ff;
   logic [7:0]            aligned_in  [LENGTH_LIMIT];
   logic [7:0]            aligned_ff  [LENGTH_LIMIT];
   logic [LENGTH_LIMIT-1:0] mask_in,  mask_ff;
   logic [7:0]            pat_bytes   [PAT_BYTES];

   logic [7:0]            window_in   [LENGTH_LIMIT];
   logic [7:0]            window_ff   [LENGTH_LIMIT];
   logic [COUNT_W-1:0]    count_in,   count_ff;
   logic                  s1_valid_ff;
   logic                  s1_start_ff;
   logic                  s1_end_ff;

   logic                  found_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff;

   logic                  advance;
   logic                  take;
   logic [LENGTH_LIMIT-1:0] eq;
   logic                  match;
   logic                  found_in;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_len_ff <= LEN_W'(1);
         for (int r = 0; r < PAT_REGS; r++) begin
            pat_word_ff[r] <= '0;
         end
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_PATTERN_LENGTH: pat_len_ff     <= csr_data[LEN_W-1:0];
            CSR_PATTERN_BYTES0: pat_word_ff[0] <= csr_data;
            CSR_PATTERN_BYTES1: pat_word_ff[1] <= csr_data;
            CSR_PATTERN_BYTES2: pat_word_ff[2] <= csr_data;
            CSR_PATTERN_BYTES3: pat_word_ff[3] <= csr_data;
            default: ;
         endcase
      end
   end

   // effective length and the pattern laid out in window order
   always_comb begin
      if (pat_len_ff == '0) begin
         len_in = LEN_W'(1);
      end else if (32'(pat_len_ff) > LENGTH_LIMIT) begin
         len_in = LEN_W'(LENGTH_LIMIT);
      end else begin
         len_in = pat_len_ff;
      end
      for (int j = 0; j < PAT_BYTES; j++) begin
         pat_bytes[j] = pat_word_ff[j / 8][(j % 8) * 8 +: 8];
      end
      for (int k = 0; k < LENGTH_LIMIT; k++) begin
         mask_in[k]    = (k < 32'(len_in));
         aligned_in[k] = pat_bytes[PAT_IDX_W'(32'(len_in) - 1 - k)];
      end
   end

   always_ff @(posedge clock) begin
      len_ff     <= len_in;
      mask_ff    <= mask_in;
      aligned_ff <= aligned_in;
   end

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   always_comb begin
      window_in[0] = req.text_byte;
      for (int k = 1; k < LENGTH_LIMIT; k++) begin
         window_in[k] = req.text_start ? 8'h00 : window_ff[k-1];
      end
      if (req.text_start) begin
         count_in = COUNT_W'(1);
      end else if (32'(count_ff) < MAX_PATTERN) begin
         count_in = COUNT_W'(count_ff + COUNT_W'(1));
      end else begin
         count_in = count_ff;
      end
   end

   always_comb begin
      for (int k = 0; k < LENGTH_LIMIT; k++) begin
         eq[k] = !mask_ff[k] || (window_ff[k] == aligned_ff[k]);
      end
      match    = (32'(count_ff) >= 32'(len_ff)) && (&eq);
      found_in = (found_ff && !s1_start_ff) || match;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         count_ff     <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            s1_valid_ff <= 1'b1;
            count_ff    <= count_in;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= s1_valid_ff;
            if (s1_valid_ff) begin
               found_ff <= found_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         window_ff   <= window_in;
         s1_start_ff <= req.text_start;
         s1_end_ff   <= req.text_end;
      end
      if (advance && s1_valid_ff) begin
         rsp_ff.match_here   <= match;
         rsp_ff.found_so_far <= found_in;
         rsp_ff.is_final     <= s1_end_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

>>> rtl/smsu_checker.sv
// Port-level checker for substring_match_stream_unit, bound to the top level.
// Depends on smsu_pkg.
module smsu_checker
   import smsu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  req_type               req,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsp_type               rsp,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
      else $error("stalled response changed");

   a_match_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.match_here |-> rsp.found_so_far)
      else $error("match reported without found flag");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

   a_no_stall_idle: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with empty output");

endmodule

bind substring_match_stream_unit smsu_checker u_smsu_checker (.*);
